[sv/mcs_pkg.sv]
// shared constants and types for the maximum clique search core
`default_nettype none

package mcs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ROW_W = 64;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CNT_W = 7;

  typedef struct packed {
    logic             en;
    logic [AW-1:0]    addr;
    logic [ROW_W-1:0] data;
  } row_wr_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } srch_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ROW_W-1:0] bits;
    logic [CNT_W-1:0] size;
  } srch_res_t;

endpackage

`default_nettype wire

[sv/mcs_engine.sv]
// adjacency row memory and branch-and-bound search sequencer
`default_nettype none

module mcs_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mcs_pkg::row_wr_t   row_wr,
  input  wire mcs_pkg::srch_cmd_t cmd,
  input  wire logic               res_ack,
  output mcs_pkg::srch_res_t      res,
  output logic                    busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int ROW_W = mcs_pkg::ROW_W;
  localparam int AW = mcs_pkg::AW;
  localparam int CNT_W = mcs_pkg::CNT_W;

  logic [ROW_W-1:0] mem [mcs_pkg::MAX_VERTICES];
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_en;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [ROW_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] cur_size_r, cur_size_nxt;
  logic [ROW_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0] best_size_r, best_size_nxt;
  logic [ROW_W-1:0] inc_r, inc_nxt;
  logic [ROW_W-1:0] exc_r, exc_nxt;

  logic [ROW_W-1:0] bit_d;
  logic [CNT_W-1:0] size_excl;
  logic [CNT_W:0]   bound;

  always_ff @(posedge clk) begin
    if (row_wr.en) begin
      mem[row_wr.addr] <= row_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[d_r[AW-1:0]];
    end
  end

  assign bit_d = {{(ROW_W-1){1'b0}}, 1'b1} << d_r[AW-1:0];
  assign size_excl = ((cur_r & bit_d) != '0) ? cur_size_r - CNT_W'(1) : cur_size_r;
  assign bound = {1'b0, size_excl} + {1'b0, n_r - d_r};

  always_comb begin
    state_nxt = state_r;
    d_nxt = d_r;
    n_nxt = n_r;
    cur_nxt = cur_r;
    cur_size_nxt = cur_size_r;
    best_nxt = best_r;
    best_size_nxt = best_size_r;
    inc_nxt = inc_r;
    exc_nxt = exc_r;
    rd_en = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt = S_READ;
          n_nxt = cmd.n;
          d_nxt = '0;
          cur_nxt = '0;
          cur_size_nxt = '0;
          best_nxt = '0;
          best_size_nxt = '0;
          inc_nxt = '0;
          exc_nxt = '0;
        end
      end
      S_READ: begin
        if (d_r >= n_r) begin
          // leaf: keep strictly larger cliques only
          if (cur_size_r > best_size_r) begin
            best_nxt = cur_r;
            best_size_nxt = cur_size_r;
          end
          if (d_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            d_nxt = d_r - CNT_W'(1);
          end
        end else begin
          rd_en = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = S_READ;
        if ((inc_r & bit_d) == '0) begin
          inc_nxt = inc_r | bit_d;
          if ((cur_r & ~rd_data_r) == '0) begin
            cur_nxt = cur_r | bit_d;
            cur_size_nxt = cur_size_r + CNT_W'(1);
            d_nxt = d_r + CNT_W'(1);
          end
        end else if ((exc_r & bit_d) == '0 && bound > {1'b0, best_size_r}) begin
          exc_nxt = exc_r | bit_d;
          cur_nxt = cur_r & ~bit_d;
          cur_size_nxt = size_excl;
          d_nxt = d_r + CNT_W'(1);
        end else begin
          // both branches done, or exclude pruned by the bound: backtrack
          cur_nxt = cur_r & ~bit_d;
          cur_size_nxt = size_excl;
          inc_nxt = inc_r & ~bit_d;
          exc_nxt = exc_r & ~bit_d;
          if (d_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            d_nxt = d_r - CNT_W'(1);
          end
        end
      end
      S_FIN: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      d_r <= '0;
      n_r <= '0;
      cur_r <= '0;
      cur_size_r <= '0;
      best_r <= '0;
      best_size_r <= '0;
      inc_r <= '0;
      exc_r <= '0;
    end else begin
      state_r <= state_nxt;
      d_r <= d_nxt;
      n_r <= n_nxt;
      cur_r <= cur_nxt;
      cur_size_r <= cur_size_nxt;
      best_r <= best_nxt;
      best_size_r <= best_size_nxt;
      inc_r <= inc_nxt;
      exc_r <= exc_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign res.done = (state_r == S_FIN);
  assign res.bits = best_r;
  assign res.size = best_size_r;

`ifndef SYNTHESIS
  a_size_count: assert property (@(posedge clk) disable iff (!rst_n)
    cur_size_r == CNT_W'($countones(cur_r)))
    else $error("current size does not match member count");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> d_r <= n_r)
    else $error("search depth beyond vertex count");
  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> best_size_r <= n_r)
    else $error("best size beyond vertex count");
  a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> $past(state_r) == S_READ)
    else $error("step without row read");
`endif

endmodule

`default_nettype wire

[sv/maximum_clique_search_core.sv]
// top level: row loading, vertex count register and result register
// search: a last row word starts a search that reads a row for each step and checks each
//   leaf, then ends in a free output register; a step is one include, exclude or backtrack
// throughput: one row word per cycle while idle; none is taken from a last row word
//   until its result enters the output register
// reset: synchronous active-low; vertex count 64, no result pending, row memory undefined
`default_nettype none

module maximum_clique_search_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  in_row_index,
  input  wire logic [63:0] in_row_bits,
  input  wire logic        in_last_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_clique_bits,
  output logic [6:0]       out_member_count,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);

  localparam int CNT_W = mcs_pkg::CNT_W;

  logic [CNT_W-1:0]   vcount_r;
  logic               out_valid_r;
  logic [63:0]        out_bits_r;
  logic [CNT_W-1:0]   out_size_r;
  logic               in_fire;
  logic               busy;
  logic               res_ack;
  mcs_pkg::row_wr_t   row_wr;
  mcs_pkg::srch_cmd_t cmd;
  mcs_pkg::srch_res_t res;

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  assign row_wr.en = in_fire;
  assign row_wr.addr = in_row_index;
  assign row_wr.data = in_row_bits;

  assign cmd.start = in_fire && in_last_row;
  assign cmd.n = (vcount_r > CNT_W'(mcs_pkg::MAX_VERTICES)) ?
                 CNT_W'(mcs_pkg::MAX_VERTICES) : vcount_r;

  assign res_ack = res.done && (!out_valid_r || out_ready);

  mcs_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .row_wr  (row_wr),
    .cmd     (cmd),
    .res_ack (res_ack),
    .res     (res),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CNT_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      if (res_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_bits_r <= res.bits;
      out_size_r <= res.size;
    end
  end

  assign out_valid = out_valid_r;
  assign out_clique_bits = out_bits_r;
  assign out_member_count = out_size_r;

endmodule

`default_nettype wire
